// File: hdl/voc_block_stream_parser_macros.svh
// Assertion macros for the VOC block stream parser.
`ifndef VOC_BLOCK_STREAM_PARSER_MACROS_SVH
`define VOC_BLOCK_STREAM_PARSER_MACROS_SVH

// Assert a property, clocked on clk, disabled during reset.
`define VOC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Assert a property that holds during reset as well.
`define VOC_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/vocbsp_pkg.sv
`timescale 1ns / 1ps
package vocbsp_pkg;

	localparam int SigLen = 19;
	localparam logic [7:0] SIGNATURE [0:SigLen-1] = '{
		8'h43, 8'h72, 8'h65, 8'h61, 8'h74, 8'h69, 8'h76, 8'h65, 8'h20, 8'h56,
		8'h6F, 8'h69, 8'h63, 8'h65, 8'h20, 8'h46, 8'h69, 8'h6C, 8'h65
	};

	localparam logic [7:0] KIND_DATA     = 8'd1;
	localparam logic [7:0] KIND_CONT     = 8'd2;
	localparam logic [7:0] KIND_SILENCE  = 8'd3;
	localparam logic [7:0] KIND_EXTENDED = 8'd8;
	localparam logic [7:0] KIND_DATA_16  = 8'd9;
	localparam logic [15:0] FMT_ALAW     = 16'd6;
	localparam logic [15:0] FMT_MU255    = 16'd7;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_TERM     = 3'd1;
	localparam logic [2:0] ST_HDR      = 3'd2;
	localparam logic [2:0] ST_ZERO     = 3'd3;
	localparam logic [2:0] ST_MISMATCH = 3'd4;
	localparam logic [2:0] ST_PACKED   = 3'd5;
	localparam logic [2:0] ST_SIZE     = 3'd6;
	localparam logic [2:0] ST_BUSY     = 3'd7;

	// parse phases kept by the datapath; codes from 0 to 15
	typedef enum logic [3:0] {
		P_HDR     = 4'd0,
		P_SKIPHDR = 4'd1,
		P_TYPE    = 4'd2,
		P_LEN     = 4'd3,
		P_DATA1   = 4'd4,
		P_DATA16  = 4'd5,
		P_SIL     = 4'd6,
		P_EXT     = 4'd7,
		P_SKIP    = 4'd8,
		P_AUDIO   = 4'd9,
		P_TERM    = 4'd10,
		E_HDR     = 4'd11,
		E_ZERO    = 4'd12,
		E_MISMATCH = 4'd13,
		E_PACKED  = 4'd14,
		E_SIZE    = 4'd15
	} phase_t;

	// controller to datapath
	typedef struct packed {
		logic load;     // capture input transaction
		logic exec;     // apply byte / drain
		logic div_start;
		logic div_step;
		logic div_done; // write silence result
		logic out_load;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_div;
		logic div_last;
	} dp_sts_t;

	localparam int DivSteps = 24;

	function automatic logic [15:0] ulaw_sample(input logic [7:0] b);
		logic [7:0] u;
		logic [15:0] t;
		logic [15:0] v;
		u = ~b;
		t = ({9'd0, u[3:0], 3'd0} + 16'h84) << u[6:4];
		v = u[7] ? (16'h84 - t) : (t - 16'h84);
		return v;
	endfunction

	function automatic logic [15:0] alaw_sample(input logic [7:0] b);
		logic [7:0] a;
		logic [2:0] seg;
		logic [15:0] t;
		a = b ^ 8'h55;
		seg = a[6:4];
		t = {8'd0, a[3:0], 4'd0};
		if (seg == 3'd0) t = t + 16'd8;
		else if (seg == 3'd1) t = t + 16'h108;
		else t = (t + 16'h108) << (seg - 3'd1);
		return a[7] ? t : (16'd0 - t);
	endfunction

endpackage

// File: hdl/voc_block_stream_parser.sv
`timescale 1ns / 1ps
// VOC block stream parser. Accepts one file byte (op 0) or one silence drain (op 1) per
// transaction and returns exactly one result transaction each. A transaction passes
// through the controller steps capture, execute and output; the last byte of a silence
// block whose rate code differs from a known rate below 256 also passes through the
// bit-serial divider that rescales the silence period. Output fields stay valid while
// out_valid is high and out_stall holds them.
module voc_block_stream_parser
	import vocbsp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               op,
	input  logic [7:0]         file_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] sample,
	output logic               sample_valid,
	output logic [2:0]         status,
	output logic [7:0]         channel_count,
	output logic [31:0]        rate_code,
	output logic               in_silence
);

	dp_cmd_t cmd;
	dp_sts_t sts;
	logic signed [31:0] sample_w;
	logic               sample_valid_w;
	logic [2:0]         status_w;
	logic [7:0]         channel_w;
	logic [31:0]        rate_w;
	logic               silence_w;

	vocbsp_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .cmd, .sts
	);

	vocbsp_dp u_dp (
		.clk, .arst_n, .op, .file_byte, .cmd, .sts,
		.sample(sample_w), .sample_valid(sample_valid_w), .status(status_w),
		.channel_count(channel_w), .rate_code(rate_w), .in_silence(silence_w)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
			status <= ST_OK;
			channel_count <= 8'd1;
			rate_code <= '0;
			in_silence <= 1'b0;
			sample <= '0;
		end else if (cmd.out_load) begin
			sample <= sample_w;
			sample_valid <= sample_valid_w;
			status <= status_w;
			channel_count <= channel_w;
			rate_code <= rate_w;
			in_silence <= silence_w;
		end
	end

endmodule

// File: hdl/vocbsp_ctrl.sv
`timescale 1ns / 1ps
module vocbsp_ctrl
	import vocbsp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	output dp_cmd_t  cmd,
	input  dp_sts_t  sts
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EXEC = 4'b0010,
		S_DIV  = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic out_valid_q, out_valid_d;

	always_comb begin
		state_d = state_q;
		out_valid_d = out_valid_q;
		cmd = '0;
		if (out_valid_q && !out_stall) out_valid_d = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.need_div) begin
					cmd.div_start = 1'b1;
					state_d = S_DIV;
				end else begin
					cmd.exec = 1'b1;
					state_d = S_OUT;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					cmd.div_done = 1'b1;
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					out_valid_d = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

endmodule

// File: hdl/vocbsp_dp.sv
`timescale 1ns / 1ps
module vocbsp_dp
	import vocbsp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               op,
	input  logic [7:0]         file_byte,
	input  dp_cmd_t            cmd,
	output dp_sts_t            sts,
	output logic signed [31:0] sample,
	output logic               sample_valid,
	output logic [2:0]         status,
	output logic [7:0]         channel_count,
	output logic [31:0]        rate_code,
	output logic               in_silence
);

	logic        op_q;
	logic [7:0]  b_q;
	phase_t      phase_q, phase_d;
	logic [4:0]  cnt_q, cnt_d;
	logic [15:0] pos_q, pos_d;
	logic [15:0] offs_q, offs_d;
	logic [7:0]  kind_q, kind_d;
	logic [23:0] blen_q, blen_d;
	logic [23:0] left_q, left_d;
	logic [31:0] shift_q, shift_d;
	logic [31:0] rate_q, rate_d;
	logic        rknown_q, rknown_d;
	logic        ext_q, ext_d;
	logic        word_q, word_d;
	logic [15:0] fmt_q, fmt_d;
	logic [7:0]  chan_q, chan_d;
	logic [7:0]  low_q, low_d;
	logic [15:0] sil_q, sil_d;
	logic [31:0] smp_d;
	logic        valid_d;
	logic [2:0]  st_d;

	// restoring divider: period*(256-b) / (256-rate)
	logic [23:0] dq_q;
	logic [8:0]  dr_q;
	logic [8:0]  dd_q;
	logic [4:0]  dcnt_q;
	logic [9:0]  dtrial;

	logic [31:0] fpos;
	logic [15:0] pos_inc;
	logic        sil_div;
	logic [8:0]  rate9;

	function automatic logic [2:0] phase_status(input phase_t p);
		case (p)
			P_TERM:     return ST_TERM;
			E_HDR:      return ST_HDR;
			E_ZERO:     return ST_ZERO;
			E_MISMATCH: return ST_MISMATCH;
			E_PACKED:   return ST_PACKED;
			E_SIZE:     return ST_SIZE;
			default:    return ST_OK;
		endcase
	endfunction

	assign rate9 = rate_q[8:0];
	assign sil_div = !op_q && sil_q == 16'd0 && phase_q == P_SIL && cnt_q >= 5'd2
		&& b_q != 8'd0 && rknown_q && {24'd0, b_q} != rate_q && rate_q < 32'd256;
	assign sts.need_div = sil_div;
	assign sts.div_last = (dcnt_q == 5'(DivSteps - 1));
	assign dtrial = {dr_q, dq_q[23]} - {1'b0, dd_q};
	assign pos_inc = (pos_q < 16'hFFFF) ? pos_q + 16'd1 : pos_q;
	assign fpos = {24'd0, b_q} << {cnt_q[1:0], 3'd0};

	always_comb begin
		phase_d = phase_q; cnt_d = cnt_q; pos_d = pos_q; offs_d = offs_q;
		kind_d = kind_q; blen_d = blen_q; left_d = left_q; shift_d = shift_q;
		rate_d = rate_q; rknown_d = rknown_q; ext_d = ext_q; word_d = word_q;
		fmt_d = fmt_q; chan_d = chan_q; low_d = low_q; sil_d = sil_q;
		smp_d = '0; valid_d = 1'b0; st_d = ST_OK;
		if (op_q) begin
			if (sil_q != 16'd0) begin
				sil_d = sil_q - 16'd1;
				valid_d = 1'b1;
			end
			st_d = phase_status(phase_q);
		end else if (sil_q != 16'd0) begin
			st_d = ST_BUSY;
		end else if (phase_q >= P_TERM) begin
			st_d = phase_status(phase_q);
		end else begin
			pos_d = pos_inc;
			case (phase_q)
				P_HDR: begin
					if (pos_q < 16'(SigLen)) begin
						if (b_q != SIGNATURE[pos_q[4:0]]) phase_d = E_HDR;
					end else if (pos_q == 16'd20) begin
						offs_d = {8'd0, b_q};
					end else if (pos_q == 16'd21) begin
						offs_d = {b_q, offs_q[7:0]};
						phase_d = (offs_d > 16'd22) ? P_SKIPHDR : P_TYPE;
					end
				end
				P_SKIPHDR: begin
					if (pos_inc >= offs_q) phase_d = P_TYPE;
				end
				P_TYPE: begin
					if (b_q == 8'd0) phase_d = P_TERM;
					else begin
						kind_d = b_q; cnt_d = '0; shift_d = '0; phase_d = P_LEN;
					end
				end
				P_LEN: begin
					shift_d = shift_q | fpos;
					cnt_d = cnt_q + 5'd1;
					if (cnt_q + 5'd1 >= 5'd3) begin
						blen_d = shift_d[23:0];
						cnt_d = '0; shift_d = '0;
						if (kind_q == KIND_DATA) phase_d = P_DATA1;
						else if (kind_q == KIND_DATA_16) phase_d = P_DATA16;
						else if (kind_q == KIND_SILENCE) phase_d = P_SIL;
						else if (kind_q == KIND_EXTENDED) begin
							ext_d = 1'b1; phase_d = P_EXT;
						end else begin
							left_d = blen_d;
							phase_d = (blen_d != 24'd0)
								? ((kind_q == KIND_CONT) ? P_AUDIO : P_SKIP) : P_TYPE;
						end
					end
				end
				P_DATA1: begin
					cnt_d = cnt_q + 5'd1;
					if (cnt_q == 5'd0) begin
						if (!ext_q) begin
							if (b_q == 8'd0) phase_d = E_ZERO;
							else if (rknown_q && {24'd0, b_q} != rate_q) phase_d = E_MISMATCH;
							else begin
								rate_d = {24'd0, b_q}; rknown_d = 1'b1; chan_d = 8'd1;
							end
						end
					end else if (b_q != 8'd0) begin
						phase_d = E_PACKED;
					end else begin
						ext_d = 1'b0; word_d = 1'b0; cnt_d = '0;
						left_d = (blen_q >= 24'd2) ? blen_q - 24'd2 : 24'd0;
						phase_d = (left_d != 24'd0) ? P_AUDIO : P_TYPE;
					end
				end
				P_DATA16: begin
					cnt_d = cnt_q + 5'd1;
					if (cnt_q < 5'd4) begin
						shift_d = shift_q | fpos;
						if (cnt_q == 5'd3) begin
							if (shift_d == 32'd0) phase_d = E_ZERO;
							else if (rknown_q && shift_d != rate_q) phase_d = E_MISMATCH;
							else begin
								rate_d = shift_d; rknown_d = 1'b1;
							end
						end
					end else if (cnt_q == 5'd4) begin
						if (b_q == 8'd8) word_d = 1'b0;
						else if (b_q == 8'd16) word_d = 1'b1;
						else phase_d = E_SIZE;
					end else if (cnt_q == 5'd5) begin
						chan_d = b_q;
					end else if (cnt_q == 5'd6) begin
						fmt_d = {8'd0, b_q};
					end else if (cnt_q == 5'd7) begin
						fmt_d = {b_q, fmt_q[7:0]};
					end else if (cnt_q >= 5'd11) begin
						cnt_d = '0;
						left_d = (blen_q >= 24'd12) ? blen_q - 24'd12 : 24'd0;
						phase_d = (left_d != 24'd0) ? P_AUDIO : P_TYPE;
					end
				end
				P_SIL: begin
					cnt_d = cnt_q + 5'd1;
					if (cnt_q == 5'd0) shift_d = {24'd0, b_q};
					else if (cnt_q == 5'd1) shift_d = {16'd0, b_q, shift_q[7:0]};
					else if (b_q == 8'd0) phase_d = E_ZERO;
					else begin
						// scaled case handled by the divider
						if (!(rknown_q && {24'd0, b_q} != rate_q)) begin
							rate_d = {24'd0, b_q}; rknown_d = 1'b1;
						end
						sil_d = shift_q[15:0];
						phase_d = P_TYPE;
					end
				end
				P_EXT: begin
					cnt_d = cnt_q + 5'd1;
					if (cnt_q == 5'd0) shift_d = {24'd0, b_q};
					else if (cnt_q == 5'd1) begin
						shift_d = {16'd0, b_q, shift_q[7:0]};
						if (shift_d == 32'd0) phase_d = E_ZERO;
						else if (rknown_q && shift_d != rate_q) phase_d = E_MISMATCH;
						else begin
							rate_d = shift_d; rknown_d = 1'b1;
						end
					end else if (cnt_q == 5'd2) begin
						if (b_q != 8'd0) phase_d = E_PACKED;
					end else begin
						chan_d = (b_q != 8'd0) ? 8'd2 : 8'd1;
						phase_d = P_TYPE;
					end
				end
				P_SKIP: begin
					if (left_q != 24'd0) left_d = left_q - 24'd1;
					if (left_d == 24'd0) phase_d = P_TYPE;
				end
				P_AUDIO: begin
					if (word_q) begin
						if (cnt_q == 5'd0) begin
							low_d = b_q; cnt_d = 5'd1;
						end else begin
							smp_d = {b_q, low_q, 16'd0};
							valid_d = 1'b1; cnt_d = '0;
						end
					end else begin
						if (fmt_q == FMT_MU255) smp_d = {ulaw_sample(b_q), 16'd0};
						else if (fmt_q == FMT_ALAW) smp_d = {alaw_sample(b_q), 16'd0};
						else smp_d = {b_q ^ 8'h80, 24'd0};
						valid_d = 1'b1;
					end
					if (left_q != 24'd0) left_d = left_q - 24'd1;
					if (left_d == 24'd0) phase_d = P_TYPE;
				end
				default: ;
			endcase
			st_d = phase_status(phase_d);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op;
			b_q <= file_byte;
		end
		if (cmd.div_start) begin
			dq_q <= shift_q[15:0] * (9'd256 - {1'b0, b_q});
			dr_q <= '0;
			dd_q <= 9'd256 - rate9;
		end else if (cmd.div_step) begin
			if (!dtrial[9]) begin
				dr_q <= dtrial[8:0];
				dq_q <= {dq_q[22:0], 1'b1};
			end else begin
				dr_q <= {dr_q[7:0], dq_q[23]};
				dq_q <= {dq_q[22:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_HDR; cnt_q <= '0; pos_q <= '0; offs_q <= '0;
			kind_q <= '0; blen_q <= '0; left_q <= '0; shift_q <= '0;
			rate_q <= '0; rknown_q <= 1'b0; ext_q <= 1'b0; word_q <= 1'b0;
			fmt_q <= '0; chan_q <= 8'd1; low_q <= '0; sil_q <= '0;
			dcnt_q <= '0;
			sample <= '0; sample_valid <= 1'b0; status <= ST_OK;
		end else begin
			if (cmd.div_start) dcnt_q <= '0;
			else if (cmd.div_step) dcnt_q <= dcnt_q + 5'd1;
			if (cmd.exec) begin
				phase_q <= phase_d;
				cnt_q <= cnt_d; pos_q <= pos_d; offs_q <= offs_d;
				kind_q <= kind_d; blen_q <= blen_d; left_q <= left_d; shift_q <= shift_d;
				rate_q <= rate_d; rknown_q <= rknown_d; ext_q <= ext_d; word_q <= word_d;
				fmt_q <= fmt_d; chan_q <= chan_d; low_q <= low_d; sil_q <= sil_d;
				sample <= smp_d; sample_valid <= valid_d; status <= st_d;
			end
			if (cmd.div_done) begin
				pos_q <= pos_inc;
				cnt_q <= cnt_q + 5'd1;
				phase_q <= P_TYPE;
				// final quotient bit comes from the last step
				if ((dq_q[22:0] != 23'd0) || (dq_q[23:16] != 8'd0) || !dtrial[9] ||
					(dq_q[22:15] != 8'd0))
					sil_q <= ({dq_q[22:0], ~dtrial[9]} > 24'hFFFF) ? 16'hFFFF
						: {dq_q[14:0], ~dtrial[9]};
				else
					sil_q <= 16'd0;
				sample <= '0; sample_valid <= 1'b0; status <= ST_OK;
			end
		end
	end

	assign channel_count = chan_q;
	assign rate_code = rate_q;
	assign in_silence = (sil_q != 16'd0);

endmodule

// File: hdl/vocbsp_checker.sv
`timescale 1ns / 1ps
`include "voc_block_stream_parser_macros.svh"
module vocbsp_checker
	import vocbsp_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] sample,
	input logic               sample_valid,
	input logic [2:0]         status,
	input logic               in_silence
);

	`VOC_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(sample), "held result changed")
	`VOC_ASSERT(a_zero_sample, out_valid && !sample_valid |-> sample == 32'sd0, "sample without valid")
	`VOC_ASSERT(a_accept_stalls, in_valid && !in_stall |=> in_stall, "second transaction taken")
	`VOC_ASSERT(a_busy_pending, out_valid && status == ST_BUSY |-> in_silence && !sample_valid, "bad busy")
	`VOC_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !out_valid, "result during reset")

endmodule

bind voc_block_stream_parser vocbsp_checker u_vocbsp_checker (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall,
	.sample, .sample_valid, .status, .in_silence
);
